// ===== design/bitmask_rank_select_macros.svh =====
// Assertion macros for the bitmask rank/select block.
// Used by the RTL files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef BITMASK_RANK_SELECT_MACROS_SVH
`define BITMASK_RANK_SELECT_MACROS_SVH
`ifndef SYNTHESIS
// implication checked on every edge out of reset
`define BMRS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bmrs: assertion failed");
// same, message names the datapath
`define BMRS_ASSERT_DP(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bmrs: datapath assertion failed");
`else
`define BMRS_ASSERT(label, prop)
`define BMRS_ASSERT_DP(label, prop)
`endif
`endif

// ===== design/bmrs_pkg.sv =====
// Shared types, codes and popcount helpers for the bitmask rank/select block.
// No dependencies; used by every module of the block except bmrs_ram.
`default_nettype none
package bmrs_pkg;

	localparam int WORD_W    = 64;
	localparam int SUB_W     = 6;   // bit offset within a word
	localparam int PC_W      = 7;   // popcount of one word, 0..64
	localparam int RES_W     = 8;
	localparam int IN_TDATA_W = 88; // 85 field bits padded to bytes

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_RANK   = 2'd1,
		OP_SELECT = 2'd2
	} bmrs_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_KTH,
		ST_HOLD
	} bmrs_state_t;

	typedef struct packed {
		logic [PC_W-1:0] pc_all;
		logic [PC_W-1:0] pc_below;
		logic            bit_set;
	} word_stat_t;

	function automatic logic [3:0] popcnt8(input logic [7:0] v);
		logic [3:0] c;
		c = '0;
		for (int b = 0; b < 8; b++) begin
			c = c + 4'(v[b]);
		end
		return c;
	endfunction

	function automatic logic [PC_W-1:0] popcnt64(input logic [WORD_W-1:0] v);
		logic [PC_W-1:0] c;
		c = '0;
		for (int i = 0; i < 8; i++) begin
			c = c + PC_W'(popcnt8(v[8*i +: 8]));
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== design/bitmask_rank_select.sv =====
// Rank/select over a MASK_WORDS x 64-bit mask in a RAM with registered read data (bmrs_ram),
// with bmrs_word_stat, bmrs_kth and bmrs_pkg. One transaction in flight; a load goes
// straight to the result, a rank scans the words up to its bit's word and a select scans the
// words in use (one RAM word per scan cycle, then the 3-stage k-th-one search on a hit).
// s_tready returns once the result sits in the output register. Reset clears the per-word
// valid flags, so the mask reads as zero at once; no clearing pass.
`default_nettype none
`include "bitmask_rank_select_macros.svh"
module bitmask_rank_select #(
	parameter int MASK_WORDS = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// word_index[1:0], mask_word[65:2], word_count[68:66], bit_number[76:69],
	// position[84:77], zero pad [87:85]
	input  wire logic [bmrs_pkg::IN_TDATA_W-1:0]   s_tdata,
	// operation[1:0]
	input  wire logic [1:0]                        s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// result_index[7:0]
	output logic      [bmrs_pkg::RES_W-1:0]        m_tdata,
	// valid_res[0]
	output logic                                   m_tuser
);

	localparam int AW = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;
	localparam int LW = $clog2(MASK_WORDS + 1);
	localparam int CW = $clog2(MASK_WORDS * 64 + 1);
	localparam int EW = ((CW > 8) ? CW : 8) + 1;

	// input fields
	logic [1:0]                    word_index;
	logic [bmrs_pkg::WORD_W-1:0]   mask_word;
	logic [2:0]                    word_count;
	logic [7:0]                    bit_number;
	logic [7:0]                    position;

	assign word_index = s_tdata[1:0];
	assign mask_word  = s_tdata[65:2];
	assign word_count = s_tdata[68:66];
	assign bit_number = s_tdata[76:69];
	assign position   = s_tdata[84:77];

	// control state
	bmrs_pkg::bmrs_state_t         state_q, state_d;
	logic [AW-1:0]                 pj_q, pj_d;      // word under scan
	logic [CW-1:0]                 acc_q, acc_d;    // ones seen in lower words
	logic [LW-1:0]                 lim_q, lim_d;    // words to scan
	logic                          sel_q, sel_d;    // select, else rank
	logic [bmrs_pkg::SUB_W-1:0]    sub_q, sub_d;
	logic [7:0]                    pos_q, pos_d;
	logic [bmrs_pkg::RES_W-1:0]    res_idx_q, res_idx_d;
	logic                          res_vld_q, res_vld_d;
	logic                          m_tvalid_q;
	logic [bmrs_pkg::RES_W-1:0]    out_idx_q;
	logic                          out_vld_q;
	logic                          out_load;

	// per-word valid flags: unwritten words read as zero
	logic [MASK_WORDS-1:0]         wvld_q;
	logic                          rdv_s1;

	// memory port
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [AW-1:0]                 rd_addr;
	logic [bmrs_pkg::WORD_W-1:0]   rd_data;
	logic [bmrs_pkg::WORD_W-1:0]   scan_word;

	// scan datapath
	bmrs_pkg::word_stat_t          stat;
	logic [AW:0]                   pj_nx;
	logic [LW-1:0]                 cnt_sat;
	logic [EW-1:0]                 seen_sum;
	logic                          hit;
	logic [bmrs_pkg::SUB_W-1:0]    kth_k;
	logic                          kth_start;
	logic                          kth_done;
	logic [bmrs_pkg::SUB_W-1:0]    kth_bit;
	logic                          accept;

	assign s_tready  = (state_q == bmrs_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign ram_waddr = AW'(word_index);
	assign scan_word = rdv_s1 ? rd_data : '0;
	assign pj_nx     = {1'b0, pj_q} + (AW+1)'(1);
	assign cnt_sat   = (int'(word_count) > MASK_WORDS) ? LW'(MASK_WORDS) : LW'(word_count);
	assign seen_sum  = EW'(acc_q) + EW'(stat.pc_all);
	assign hit       = seen_sum > EW'(pos_q);
	assign kth_k     = bmrs_pkg::SUB_W'(EW'(pos_q) - EW'(acc_q));

	bmrs_ram #(
		.WIDTH (bmrs_pkg::WORD_W),
		.DEPTH (MASK_WORDS)
	) u_mask_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (mask_word),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	bmrs_word_stat u_word_stat (
		.word (scan_word),
		.sub  (sub_q),
		.stat (stat)
	);

	bmrs_kth u_kth (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (kth_start),
		.word   (scan_word),
		.k      (kth_k),
		.done   (kth_done),
		.bit_no (kth_bit)
	);

	// sequencer: one RAM word consumed per scan cycle, next word read in parallel
	always_comb begin
		state_d   = state_q;
		pj_d      = pj_q;
		acc_d     = acc_q;
		lim_d     = lim_q;
		sel_d     = sel_q;
		sub_d     = sub_q;
		pos_d     = pos_q;
		res_idx_d = res_idx_q;
		res_vld_d = res_vld_q;
		ram_we    = 1'b0;
		rd_addr   = '0;
		kth_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			bmrs_pkg::ST_IDLE: begin
				// word 0 is read here so the scan starts with its data
				pj_d      = '0;
				acc_d     = '0;
				res_idx_d = '0;
				res_vld_d = 1'b0;
				sub_d     = bit_number[bmrs_pkg::SUB_W-1:0];
				pos_d     = position;
				if (s_tvalid) begin
					state_d = bmrs_pkg::ST_HOLD;
					case (s_tuser)
						bmrs_pkg::OP_LOAD: begin
							if (int'(word_index) < MASK_WORDS) begin
								ram_we    = 1'b1;
								res_vld_d = 1'b1;
							end
						end
						bmrs_pkg::OP_RANK: begin
							if (LW'(bit_number[7:6]) < cnt_sat && int'(bit_number[7:6]) < MASK_WORDS) begin
								lim_d   = LW'(int'(bit_number[7:6]) + 1);
								sel_d   = 1'b0;
								state_d = bmrs_pkg::ST_SCAN;
							end
						end
						bmrs_pkg::OP_SELECT: begin
							if (cnt_sat != '0) begin
								lim_d   = cnt_sat;
								sel_d   = 1'b1;
								state_d = bmrs_pkg::ST_SCAN;
							end
						end
						default: begin
							// unused code: invalid result, mask left unchanged
						end
					endcase
				end
			end
			bmrs_pkg::ST_SCAN: begin
				if (pj_nx < (AW+1)'(MASK_WORDS)) begin
					rd_addr = pj_nx[AW-1:0];
				end
				if (sel_q) begin
					if (hit) begin
						kth_start = 1'b1;
						state_d   = bmrs_pkg::ST_KTH;
					end else if (pj_nx == (AW+1)'(lim_q)) begin
						state_d = bmrs_pkg::ST_HOLD;
					end else begin
						acc_d = CW'(seen_sum);
						pj_d  = pj_nx[AW-1:0];
					end
				end else begin
					if (pj_nx == (AW+1)'(lim_q)) begin
						if (stat.bit_set) begin
							res_idx_d = bmrs_pkg::RES_W'(EW'(acc_q) + EW'(stat.pc_below));
							res_vld_d = 1'b1;
						end
						state_d = bmrs_pkg::ST_HOLD;
					end else begin
						acc_d = CW'(seen_sum);
						pj_d  = pj_nx[AW-1:0];
					end
				end
			end
			bmrs_pkg::ST_KTH: begin
				if (kth_done) begin
					res_idx_d = bmrs_pkg::RES_W'({pj_q, kth_bit});
					res_vld_d = 1'b1;
					state_d   = bmrs_pkg::ST_HOLD;
				end
			end
			bmrs_pkg::ST_HOLD: begin
				// hand over to the output register once it is free
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = bmrs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bmrs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bmrs_pkg::ST_IDLE;
			wvld_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				wvld_q[ram_waddr] <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pj_q      <= pj_d;
		acc_q     <= acc_d;
		lim_q     <= lim_d;
		sel_q     <= sel_d;
		sub_q     <= sub_d;
		pos_q     <= pos_d;
		res_idx_q <= res_idx_d;
		res_vld_q <= res_vld_d;
		rdv_s1    <= wvld_q[rd_addr];
		if (out_load) begin
			out_idx_q <= res_idx_q;
			out_vld_q <= res_vld_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_idx_q;
	assign m_tuser  = out_vld_q;

	logic [AW:0] pj_ext;
	assign pj_ext = {1'b0, pj_q};

	`BMRS_ASSERT(a_one_in_flight, accept |=> !s_tready)
	`BMRS_ASSERT_DP(a_invalid_is_zero, m_tvalid && !m_tuser |-> m_tdata == '0)
	`BMRS_ASSERT_DP(a_scan_in_range, state_q == bmrs_pkg::ST_SCAN |-> pj_ext < (AW+1)'(lim_q))
	`BMRS_ASSERT(a_kth_only_in_kth, kth_done |-> state_q == bmrs_pkg::ST_KTH)
	`BMRS_ASSERT(a_load_sets_flag, ram_we |=> wvld_q[$past(ram_waddr)])

endmodule
`default_nettype wire

// ===== design/bmrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bmrs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== design/bmrs_word_stat.sv =====
// Per-word statistics for the scan: full popcount, popcount below a bit, bit test.
// Depends on bmrs_pkg.
`default_nettype none
module bmrs_word_stat (
	input  wire logic [bmrs_pkg::WORD_W-1:0] word,
	input  wire logic [bmrs_pkg::SUB_W-1:0]  sub,
	output bmrs_pkg::word_stat_t             stat
);

	logic [bmrs_pkg::WORD_W-1:0] below;

	assign below         = word & ~({bmrs_pkg::WORD_W{1'b1}} << sub);
	assign stat.pc_all   = bmrs_pkg::popcnt64(word);
	assign stat.pc_below = bmrs_pkg::popcnt64(below);
	assign stat.bit_set  = word[sub];

endmodule
`default_nettype wire

// ===== design/bmrs_kth.sv =====
// Three-stage unit giving the bit number of the k-th set bit of a 64-bit word.
// Byte-wise search then bit-wise search; depends on bmrs_pkg.
`default_nettype none
module bmrs_kth (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [bmrs_pkg::WORD_W-1:0]  word,
	input  wire logic [bmrs_pkg::SUB_W-1:0]   k,
	output logic                              done,
	output logic      [bmrs_pkg::SUB_W-1:0]   bit_no
);

	logic                          v_s1, v_s2, v_s3;
	logic [bmrs_pkg::WORD_W-1:0]   word_s1;
	logic [bmrs_pkg::SUB_W-1:0]    k_s1;
	logic [7:0]                    byte_s2;
	logic [2:0]                    bsel_s2, krem_s2;
	logic [bmrs_pkg::SUB_W-1:0]    bit_s3;

	logic [2:0] bsel, krem, bpos;

	// find the byte holding the k-th one
	always_comb begin
		logic [6:0] cum;
		logic [6:0] nxt;
		logic       found;
		cum   = '0;
		found = 1'b0;
		bsel  = '0;
		krem  = '0;
		for (int i = 0; i < 8; i++) begin
			nxt = cum + 7'(bmrs_pkg::popcnt8(word_s1[8*i +: 8]));
			if (!found && nxt > {1'b0, k_s1}) begin
				found = 1'b1;
				bsel  = 3'(i);
				krem  = 3'(k_s1 - cum[5:0]);
			end
			cum = nxt;
		end
	end

	// find the bit within that byte
	always_comb begin
		logic [3:0] cnt;
		logic       found;
		cnt   = '0;
		found = 1'b0;
		bpos  = '0;
		for (int b = 0; b < 8; b++) begin
			if (!found && byte_s2[b] && cnt == {1'b0, krem_s2}) begin
				found = 1'b1;
				bpos  = 3'(b);
			end
			cnt = cnt + 4'(byte_s2[b]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			word_s1 <= word;
			k_s1    <= k;
		end
		if (v_s1) begin
			byte_s2 <= word_s1[bsel*8 +: 8];
			bsel_s2 <= bsel;
			krem_s2 <= krem;
		end
		if (v_s2) begin
			bit_s3 <= {bsel_s2, bpos};
		end
	end

	assign done   = v_s3;
	assign bit_no = bit_s3;

endmodule
`default_nettype wire

// ===== tb/sv/tb_bitmask_rank_select.sv =====
`timescale 1ns / 1ps
// Self-checking bench for bitmask_rank_select: a directed table, then random load, rank,
// select and spare-code items, each result checked against a typed answer or a mask copy.
// Depends on bmrs_pkg for widths and operation codes; no files or arguments are read.
module tb_bitmask_rank_select;

	localparam int         NWORDS       = 4;
	localparam logic [1:0] OP_UNUSED    = 2'd3;     // spare code: mask left unchanged, invalid result
	localparam int         RANDOM_ITEMS = 1700;
	localparam int         CYCLE_LIMIT  = 500000;
	localparam int         DRAIN_CYCLES = 3 * (NWORDS + 6);
	localparam int         MAX_REPORTS  = 10;
	localparam logic       FROM_MODEL   = 1'b0;
	localparam logic       TYPED        = 1'b1;
	localparam logic [bmrs_pkg::WORD_W-1:0] ONES = '1;
	localparam logic [bmrs_pkg::WORD_W-1:0] ENDS = 64'h8000_0000_0000_0001;

	typedef struct packed {
		logic [1:0]                  op;
		logic [1:0]                  widx;
		logic [bmrs_pkg::WORD_W-1:0] word;
		logic [2:0]                  count;
		logic [7:0]                  bitno;
		logic [7:0]                  pos;
	} mask_item_t;

	typedef struct packed {
		logic [bmrs_pkg::RES_W-1:0] index;
		logic                       found;
	} mask_answer_t;

	typedef struct packed {
		mask_item_t   item;
		logic         typed;
		mask_answer_t answer;
	} plan_row_t;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic [bmrs_pkg::IN_TDATA_W-1:0] s_tdata  = '0;
	logic [1:0]                      s_tuser  = '0;
	logic                            m_tready = 1'b0;
	logic                            s_tready;
	logic                            m_tvalid;
	logic [bmrs_pkg::RES_W-1:0]      m_tdata;
	logic                            m_tuser;

	// behavioural copy of the mask and the answers still owed by the block
	logic [bmrs_pkg::WORD_W-1:0] mask_model [NWORDS];
	mask_answer_t                answers_due [$];
	plan_row_t                   plan [$];

	bit          calm;          // both sides run without idling while set
	int unsigned cycle_count;
	int unsigned failures;
	int unsigned ops_sent [4];
	int unsigned found_count;
	int unsigned invalid_count;

	always #2 clk = ~clk;

	bitmask_rank_select uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	function automatic int unsigned ones_in(input logic [bmrs_pkg::WORD_W-1:0] v);
		int unsigned c;
		c = 0;
		for (int b = 0; b < bmrs_pkg::WORD_W; b++) begin
			c += v[b];
		end
		return c;
	endfunction

	// bit number of the k-th set bit (from 0); caller keeps k below ones_in(v)
	function automatic int unsigned nth_set(input logic [bmrs_pkg::WORD_W-1:0] v,
			input int unsigned k);
		int unsigned left;
		left = k;
		for (int b = 0; b < bmrs_pkg::WORD_W; b++) begin
			if (v[b]) begin
				if (left == 0) begin
					return b;
				end
				left--;
			end
		end
		return 0;
	endfunction

	// applies one accepted transaction to the mask copy and returns the answer it must give
	function automatic mask_answer_t predict_answer(input mask_item_t it);
		mask_answer_t a;
		int unsigned  used;
		int unsigned  wsel;
		int unsigned  acc;
		int unsigned  seen;
		int unsigned  pc;
		a    = '0;
		used = (it.count > NWORDS) ? NWORDS : it.count;    // word count saturates
		case (it.op)
			bmrs_pkg::OP_LOAD: begin
				if (it.widx < NWORDS) begin
					mask_model[it.widx] = it.word;
					a.found = 1'b1;
				end
			end
			bmrs_pkg::OP_RANK: begin
				wsel = it.bitno[7:6];
				// only a set bit inside the words in use has a rank
				if (wsel < used && mask_model[wsel][it.bitno[5:0]]) begin
					acc = 0;
					for (int j = 0; j < wsel; j++) begin
						acc += ones_in(mask_model[j]);
					end
					acc += ones_in(mask_model[wsel] & ((64'd1 << it.bitno[5:0]) - 64'd1));
					a.index = acc[bmrs_pkg::RES_W-1:0];
					a.found = 1'b1;
				end
			end
			bmrs_pkg::OP_SELECT: begin
				seen = 0;
				for (int j = 0; j < used && !a.found; j++) begin
					pc = ones_in(mask_model[j]);
					if (seen + pc > it.pos) begin
						a.index = bmrs_pkg::RES_W'(j * bmrs_pkg::WORD_W +
							nth_set(mask_model[j], it.pos - seen));
						a.found = 1'b1;
					end
					seen += pc;
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	function automatic plan_row_t plan_row(input logic [1:0] op, input logic [1:0] widx,
			input logic [bmrs_pkg::WORD_W-1:0] word, input logic [2:0] count,
			input logic [7:0] bitno, input logic [7:0] pos, input logic typed,
			input logic [bmrs_pkg::RES_W-1:0] index, input logic found);
		plan_row_t r;
		r.item   = '{op: op, widx: widx, word: word, count: count, bitno: bitno, pos: pos};
		r.typed  = typed;
		r.answer = '{index: index, found: found};
		return r;
	endfunction

	// mixes sparse, dense, empty, full and single-bit words so ranks and selects span 0..255
	function automatic logic [bmrs_pkg::WORD_W-1:0] random_mask();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return ONES;
			2: return 64'd1 << $urandom_range(0, 63);
			3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			4: return {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// most queries are aimed at set bits or at positions below the set-bit total,
	// the rest are left random so the invalid paths stay busy too
	function automatic mask_item_t random_item();
		mask_item_t  it;
		int unsigned pick;
		int unsigned wsel;
		int unsigned total;
		int unsigned used;
		int unsigned hit;
		it.widx  = 2'($urandom_range(0, 3));
		it.word  = random_mask();
		it.count = ($urandom_range(0, 9) < 6) ? 3'd4 : 3'($urandom_range(0, 7));
		it.bitno = 8'($urandom_range(0, 255));
		it.pos   = 8'($urandom_range(0, 255));
		pick     = $urandom_range(0, 99);
		if (pick < 30) begin
			it.op = bmrs_pkg::OP_LOAD;
		end else if (pick < 63) begin
			it.op = bmrs_pkg::OP_RANK;
			wsel  = $urandom_range(0, NWORDS - 1);
			if ($urandom_range(0, 9) < 7 && mask_model[wsel] != '0) begin
				hit      = nth_set(mask_model[wsel],
					$urandom_range(0, ones_in(mask_model[wsel]) - 1));
				it.bitno = {wsel[1:0], hit[5:0]};
			end
		end else if (pick < 95) begin
			it.op = bmrs_pkg::OP_SELECT;
			used  = (it.count > NWORDS) ? NWORDS : it.count;
			total = 0;
			for (int j = 0; j < used; j++) begin
				total += ones_in(mask_model[j]);
			end
			if ($urandom_range(0, 9) < 7 && total > 0) begin
				it.pos = 8'($urandom_range(0, total - 1));
			end
		end else begin
			it.op = OP_UNUSED;
		end
		return it;
	endfunction

	// one transaction on the slave side; the expectation is queued at the accepting edge
	task automatic send_item(input mask_item_t it, input logic typed, input mask_answer_t given);
		int unsigned  gap;
		mask_answer_t predicted;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.op;
		s_tdata  <= {3'b000, it.pos, it.bitno, it.count, it.word, it.widx};
		do @(posedge clk); while (!s_tready);
		predicted = predict_answer(it);
		answers_due.push_back((typed == TYPED) ? given : predicted);
		ops_sent[it.op]++;
	endtask

	// sender holds off until every owed answer has come back
	task automatic wait_for_answers();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (answers_due.size() != 0);
	endtask

	// stimulus
	initial begin
		foreach (mask_model[i]) mask_model[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// queries on the cleared mask, then extremes of mask, count, bit and position
		plan.push_back(plan_row(bmrs_pkg::OP_RANK, 2'd0, '0, 3'd4, 8'd0, 8'd0, TYPED, 8'd0, 1'b0));
		plan.push_back(plan_row(bmrs_pkg::OP_SELECT, 2'd0, '0, 3'd4, 8'd0, 8'd0, TYPED, 8'd0,
			1'b0));
		plan.push_back(plan_row(OP_UNUSED, 2'd0, '0, 3'd4, 8'd0, 8'd0, TYPED, 8'd0, 1'b0));
		plan.push_back(plan_row(bmrs_pkg::OP_LOAD, 2'd0, ONES, 3'd0, 8'd0, 8'd0, TYPED, 8'd0, 1'b1));
		plan.push_back(plan_row(bmrs_pkg::OP_LOAD, 2'd1, '0, 3'd0, 8'd0, 8'd0, TYPED, 8'd0, 1'b1));
		plan.push_back(plan_row(bmrs_pkg::OP_LOAD, 2'd2, ENDS, 3'd0, 8'd0, 8'd0, TYPED, 8'd0, 1'b1));
		plan.push_back(plan_row(bmrs_pkg::OP_LOAD, 2'd3, ONES, 3'd0, 8'd0, 8'd0, TYPED, 8'd0, 1'b1));
		plan.push_back(plan_row(bmrs_pkg::OP_RANK, 2'd0, '0, 3'd1, 8'd0, 8'd0, TYPED, 8'd0, 1'b1));
		plan.push_back(plan_row(bmrs_pkg::OP_RANK, 2'd0, '0, 3'd1, 8'd63, 8'd0, TYPED, 8'd63, 1'b1));
		// bit beyond the words in use, then a clear bit
		plan.push_back(plan_row(bmrs_pkg::OP_RANK, 2'd0, '0, 3'd1, 8'd64, 8'd0, TYPED, 8'd0, 1'b0));
		plan.push_back(plan_row(bmrs_pkg::OP_RANK, 2'd0, '0, 3'd4, 8'd64, 8'd0, TYPED, 8'd0, 1'b0));
		plan.push_back(plan_row(bmrs_pkg::OP_RANK, 2'd0, '0, 3'd3, 8'd128, 8'd0, FROM_MODEL, 8'd0,
			1'b0));
		plan.push_back(plan_row(bmrs_pkg::OP_RANK, 2'd0, '0, 3'd7, 8'd255, 8'd0, FROM_MODEL, 8'd0,
			1'b0));
		plan.push_back(plan_row(bmrs_pkg::OP_RANK, 2'd0, '0, 3'd0, 8'd255, 8'd0, TYPED, 8'd0, 1'b0));
		plan.push_back(plan_row(bmrs_pkg::OP_SELECT, 2'd0, '0, 3'd0, 8'd0, 8'd0, TYPED, 8'd0,
			1'b0));
		// select past the last set bit, across word boundaries, with saturated count
		plan.push_back(plan_row(bmrs_pkg::OP_SELECT, 2'd0, '0, 3'd4, 8'd0, 8'd255, FROM_MODEL,
			8'd0, 1'b0));
		plan.push_back(plan_row(bmrs_pkg::OP_SELECT, 2'd0, '0, 3'd4, 8'd0, 8'd64, FROM_MODEL,
			8'd0, 1'b0));
		plan.push_back(plan_row(bmrs_pkg::OP_SELECT, 2'd0, '0, 3'd7, 8'd0, 8'd129, FROM_MODEL,
			8'd0, 1'b0));
		plan.push_back(plan_row(bmrs_pkg::OP_SELECT, 2'd0, '0, 3'd3, 8'd0, 8'd65, FROM_MODEL,
			8'd0, 1'b0));
		plan.push_back(plan_row(bmrs_pkg::OP_SELECT, 2'd0, '0, 3'd3, 8'd0, 8'd66, FROM_MODEL,
			8'd0, 1'b0));
		// spare code carrying load fields must leave word 1 untouched
		plan.push_back(plan_row(OP_UNUSED, 2'd1, ONES, 3'd7, 8'd255, 8'd255, TYPED, 8'd0, 1'b0));
		plan.push_back(plan_row(bmrs_pkg::OP_RANK, 2'd0, '0, 3'd4, 8'd65, 8'd0, FROM_MODEL, 8'd0,
			1'b0));
		plan.push_back(plan_row(bmrs_pkg::OP_LOAD, 2'd1, 64'hAAAA_AAAA_AAAA_AAAA, 3'd0, 8'd0,
			8'd0, FROM_MODEL, 8'd0, 1'b0));
		plan.push_back(plan_row(bmrs_pkg::OP_SELECT, 2'd0, '0, 3'd2, 8'd0, 8'd100, FROM_MODEL,
			8'd0, 1'b0));
		plan.push_back(plan_row(bmrs_pkg::OP_RANK, 2'd0, '0, 3'd5, 8'd191, 8'd0, FROM_MODEL, 8'd0,
			1'b0));

		foreach (plan[i]) begin
			send_item(plan[i].item, plan[i].typed, plan[i].answer);
		end
		wait_for_answers();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n % 400) < 50;
			if (n == RANDOM_ITEMS / 2) begin
				wait_for_answers();
			end
			send_item(random_item(), FROM_MODEL, '0);
		end
		calm = 1'b0;
		wait_for_answers();
		repeat (DRAIN_CYCLES) @(posedge clk);

		failures += answers_due.size();
		$display("Covered %0d loads, %0d rank, %0d select and %0d spare-code transactions",
			ops_sent[bmrs_pkg::OP_LOAD], ops_sent[bmrs_pkg::OP_RANK],
			ops_sent[bmrs_pkg::OP_SELECT], ops_sent[OP_UNUSED]);
		$display("Results: %0d answered, %0d invalid; %0d failures",
			found_count, invalid_count, failures);
		if (failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// master side: random back-pressure, each result checked against the oldest answer owed
	initial begin
		int unsigned  stall;
		mask_answer_t want;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (m_tuser) begin
				found_count++;
			end else begin
				invalid_count++;
			end
			if (answers_due.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS) begin
					$display("unexpected result at cycle %0d: index %0d valid %0b",
						cycle_count, m_tdata, m_tuser);
				end
			end else begin
				want = answers_due.pop_front();
				if (m_tdata !== want.index || m_tuser !== want.found) begin
					failures++;
					if (failures <= MAX_REPORTS) begin
						$display("mismatch at cycle %0d: index exp %0d got %0d, valid exp %0b got %0b",
							cycle_count, want.index, m_tdata, want.found, m_tuser);
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d results owed", cycle_count, answers_due.size());
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/bmrs_pkg.sv
design/bmrs_ram.sv
design/bmrs_word_stat.sv
design/bmrs_kth.sv
design/bitmask_rank_select.sv
tb/sv/tb_bitmask_rank_select.sv
